[hw/rtl/thermostat_hysteresis_controller_core_assert.svh]
// ----------------------------------------------------------------------------
// Thermostat controller assertion macros
// Shared concurrent assertion forms used by the thermostat controller RTL.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH
`define THERMOSTAT_HYSTERESIS_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define THC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define THC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/thc_pkg.sv]
// ----------------------------------------------------------------------------
// Thermostat controller package
// Shared widths, codes, register records and decimal helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thc_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int Q10_BITS       = SAMPLE_BITS - 3;
    localparam int Q100_BITS      = SAMPLE_BITS - 6;
    localparam int CMP_BITS       = ((SAMPLE_BITS > 9) ? SAMPLE_BITS : 9) + 1;
    localparam int KIND_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam int DIGIT_BITS     = 4;

    localparam int QUEUE_PTR_BITS   = 1;
    localparam int QUEUE_DEPTH      = 2 ** QUEUE_PTR_BITS;
    localparam int QUEUE_COUNT_BITS = QUEUE_PTR_BITS + 1;

    localparam logic [DIGIT_BITS-1:0] CODE_F     = 4'd10;
    localparam logic [DIGIT_BITS-1:0] CODE_BLANK = 4'd11;

    localparam logic [2:0] IND_OFF   = 3'b000;
    localparam logic [2:0] IND_HEAT  = 3'b001;
    localparam logic [2:0] IND_COOL  = 3'b010;
    localparam logic [2:0] IND_READY = 3'b100;

    localparam logic [1:0] SCAN_PHASE_IDLE  = 2'd0;
    localparam logic [1:0] SCAN_PHASE_FIRST = 2'd1;
    localparam logic [1:0] SCAN_PHASE_LAST  = 2'd3;

    localparam logic [7:0] RST_SETPOINT_MAX    = 8'd60;
    localparam logic [7:0] RST_SETPOINT_MIN    = 8'd35;
    localparam logic [7:0] RST_SETPOINT_STEP   = 8'd5;
    localparam logic [7:0] RST_BAND_HALF_WIDTH = 8'd5;
    localparam logic [7:0] RST_TIMEOUT_RELOAD  = 8'd20;
    localparam logic [7:0] RST_SETPOINT        = 8'd60;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SAMPLE = 3'd0,
        KIND_POWER  = 3'd1,
        KIND_UP     = 3'd2,
        KIND_DOWN   = 3'd3,
        KIND_TICK   = 3'd4,
        KIND_SCAN   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SAMPLE,
        CMD_POWER,
        CMD_UP,
        CMD_DOWN,
        CMD_TICK,
        CMD_SCAN
    } t_cmd;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SETPOINT_MAX    = 3'd0,
        CFG_SETPOINT_MIN    = 3'd1,
        CFG_SETPOINT_STEP   = 3'd2,
        CFG_BAND_HALF_WIDTH = 3'd3,
        CFG_TIMEOUT_RELOAD  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] setpoint_max;
        logic [7:0] setpoint_min;
        logic [7:0] setpoint_step;
        logic [7:0] band_half_width;
        logic [7:0] timeout_reload;
    } t_cfg;

    typedef struct packed {
        t_cmd                  cmd;
        logic [SAMPLE_BITS-1:0] sample;
        logic [DIGIT_BITS-1:0]  dig_mid;
        logic [DIGIT_BITS-1:0]  dig_low;
        logic [Q100_BITS-1:0]   q100;
    } t_entry;

    // Exact quotient by ten for any 16-bit value.
    function automatic logic [12:0] f_div10(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'd52429;
        return prod[31:19];
    endfunction

    // Remainder by ten, given the quotient already found.
    function automatic logic [DIGIT_BITS-1:0] f_rem10(input logic [15:0] x,
                                                      input logic [12:0] q);
        logic [15:0] r;
        r = x - ({q, 3'b000} + 16'({q, 1'b0}));
        return r[DIGIT_BITS-1:0];
    endfunction

endpackage

[hw/rtl/thermostat_hysteresis_controller_core.sv]
// ----------------------------------------------------------------------------
// Thermostat hysteresis controller core
// Path: a taken event passes front stages s1 and s2, the queue and the back
// end's result register. Throughput: one event per cycle while i_ready holds,
// set by the two-stage front end, two-entry queue and state-updating back end.
// Reset: synchronous, active low; control and state registers reset, data not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermostat_hysteresis_controller_core import thc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [KIND_BITS-1:0]      i_kind,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_heat_on,
    output logic                      o_cool_on,
    output logic                      o_ready_on,
    output logic                      o_powered,
    output logic                      o_adjusting,
    output logic [7:0]                o_current_setpoint,
    output logic [DIGIT_BITS-1:0]     o_digit_high,
    output logic [DIGIT_BITS-1:0]     o_digit_mid,
    output logic [DIGIT_BITS-1:0]     o_digit_low,
    output logic                      o_scan_valid,
    output logic [1:0]                o_scan_position,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg   cfg;
    logic   front_valid;
    logic   front_ready;
    t_entry front_entry;
    logic   queue_valid;
    logic   queue_ready;
    t_entry queue_entry;

    thc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    thc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_sample (i_sample),
        .o_valid  (front_valid),
        .i_ready  (front_ready),
        .o_entry  (front_entry)
    );

    thc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_entry (front_entry),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_entry (queue_entry)
    );

    thc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (queue_valid),
        .o_ready            (queue_ready),
        .i_entry            (queue_entry),
        .i_cfg              (cfg),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_heat_on          (o_heat_on),
        .o_cool_on          (o_cool_on),
        .o_ready_on         (o_ready_on),
        .o_powered          (o_powered),
        .o_adjusting        (o_adjusting),
        .o_current_setpoint (o_current_setpoint),
        .o_digit_high       (o_digit_high),
        .o_digit_mid        (o_digit_mid),
        .o_digit_low        (o_digit_low),
        .o_scan_valid       (o_scan_valid),
        .o_scan_position    (o_scan_position)
    );

endmodule

[hw/rtl/thc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Thermostat controller configuration registers
// Holds the setpoint limits, step, band and timeout reload written by the host.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thc_cfg_regs import thc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_max    <= RST_SETPOINT_MAX;
            r_cfg.setpoint_min    <= RST_SETPOINT_MIN;
            r_cfg.setpoint_step   <= RST_SETPOINT_STEP;
            r_cfg.band_half_width <= RST_BAND_HALF_WIDTH;
            r_cfg.timeout_reload  <= RST_TIMEOUT_RELOAD;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SETPOINT_MAX:    r_cfg.setpoint_max    <= i_cfg_data;
                CFG_SETPOINT_MIN:    r_cfg.setpoint_min    <= i_cfg_data;
                CFG_SETPOINT_STEP:   r_cfg.setpoint_step   <= i_cfg_data;
                CFG_BAND_HALF_WIDTH: r_cfg.band_half_width <= i_cfg_data;
                CFG_TIMEOUT_RELOAD:  r_cfg.timeout_reload  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/thc_front.sv]
// ----------------------------------------------------------------------------
// Thermostat controller front end
// Accepts event beats, classifies them and splits samples into low and mid decimal digits and the quotient by 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thc_front import thc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [KIND_BITS-1:0]   i_kind,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_entry                 o_entry
);

    logic                   r_s1_valid;
    t_cmd                   r_s1_cmd;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [Q10_BITS-1:0]    r_s1_q10;
    logic                   r_s2_valid;
    t_entry                 r_s2_entry;

    t_cmd        cmd;
    logic [12:0] q10_full;
    logic [12:0] q100_full;
    logic        adv2;
    t_entry      n_entry;

    always_comb begin
        case (t_kind'(i_kind))
            KIND_SAMPLE: cmd = CMD_SAMPLE;
            KIND_POWER:  cmd = CMD_POWER;
            KIND_UP:     cmd = CMD_UP;
            KIND_DOWN:   cmd = CMD_DOWN;
            KIND_TICK:   cmd = CMD_TICK;
            KIND_SCAN:   cmd = CMD_SCAN;
            default:     cmd = CMD_NONE;
        endcase
    end

    assign q10_full  = f_div10(16'(i_sample));
    assign q100_full = f_div10(16'(r_s1_q10));

    always_comb begin
        n_entry.cmd     = r_s1_cmd;
        n_entry.sample  = r_s1_sample;
        n_entry.dig_low = f_rem10(16'(r_s1_sample), 13'(r_s1_q10));
        n_entry.dig_mid = f_rem10(16'(r_s1_q10), q100_full);
        n_entry.q100    = q100_full[Q100_BITS-1:0];
    end

    assign adv2    = !r_s2_valid || i_ready;
    assign o_ready = !r_s1_valid || adv2;
    assign o_valid = r_s2_valid;
    assign o_entry = r_s2_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1_cmd    <= cmd;
            r_s1_sample <= i_sample;
            r_s1_q10    <= q10_full[Q10_BITS-1:0];
        end
        if (adv2) begin
            r_s2_entry <= n_entry;
        end
    end

endmodule

[hw/rtl/thc_queue.sv]
// ----------------------------------------------------------------------------
// Thermostat controller event queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thc_queue import thc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_entry
);

    t_entry                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0]   r_rd_ptr;
    logic [QUEUE_COUNT_BITS-1:0] r_count;

    logic push;
    logic pop;

    assign o_ready = (r_count != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[hw/rtl/thc_back.sv]
// ----------------------------------------------------------------------------
// Thermostat controller back end
// Applies each event to the controller state and holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "thermostat_hysteresis_controller_core_assert.svh"

module thc_back import thc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_entry                i_entry,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_heat_on,
    output logic                  o_cool_on,
    output logic                  o_ready_on,
    output logic                  o_powered,
    output logic                  o_adjusting,
    output logic [7:0]            o_current_setpoint,
    output logic [DIGIT_BITS-1:0] o_digit_high,
    output logic [DIGIT_BITS-1:0] o_digit_mid,
    output logic [DIGIT_BITS-1:0] o_digit_low,
    output logic                  o_scan_valid,
    output logic [1:0]            o_scan_position
);

    logic                  r_power;
    logic                  r_adjust;
    logic [7:0]            r_setpoint;
    logic [7:0]            r_timeout;
    logic                  r_latch;
    logic [2:0]            r_ind;
    logic [1:0]            r_phase;
    logic [DIGIT_BITS-1:0] r_sdig_high;
    logic [DIGIT_BITS-1:0] r_sdig_mid;
    logic [DIGIT_BITS-1:0] r_sdig_low;

    logic                  r_out_valid;
    logic [2:0]            r_out_ind;
    logic                  r_out_powered;
    logic                  r_out_adjusting;
    logic [7:0]            r_out_setpoint;
    logic [DIGIT_BITS-1:0] r_out_sdig_high;
    logic [DIGIT_BITS-1:0] r_out_sdig_mid;
    logic [DIGIT_BITS-1:0] r_out_sdig_low;
    logic                  r_out_scan_valid;
    logic [1:0]            r_out_scan_pos;

    logic                  n_power;
    logic                  n_adjust;
    logic [7:0]            n_setpoint;
    logic [7:0]            n_timeout;
    logic                  n_latch;
    logic [2:0]            n_ind;
    logic [1:0]            n_phase;
    logic [DIGIT_BITS-1:0] n_sdig_high;
    logic [DIGIT_BITS-1:0] n_sdig_mid;
    logic [DIGIT_BITS-1:0] n_sdig_low;
    logic                  n_scan_valid;
    logic [1:0]            n_scan_pos;

    logic                  pop;
    logic [12:0]           q1000_full;
    logic [DIGIT_BITS-1:0] hund;
    logic [CMP_BITS-1:0]   t_ext;
    logic [CMP_BITS-1:0]   sp_ext;
    logic [CMP_BITS-1:0]   band_ext;
    logic                  is_heat;
    logic                  is_cool;
    logic                  is_equal;
    logic [8:0]            up_sum;
    logic [8:0]            down_diff;
    logic [7:0]            up_sp;
    logic [7:0]            down_sp;
    logic [12:0]           sp_tens_raw;
    logic [4:0]            sp_tens5;
    logic [4:0]            sp_tens_dig;
    logic [DIGIT_BITS-1:0] sp_ones;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    assign q1000_full = f_div10(16'(i_entry.q100));
    assign hund       = f_rem10(16'(i_entry.q100), q1000_full);

    assign t_ext    = CMP_BITS'(i_entry.sample);
    assign sp_ext   = CMP_BITS'(r_setpoint);
    assign band_ext = CMP_BITS'(i_cfg.band_half_width);
    assign is_heat  = (t_ext + band_ext) <= sp_ext;
    assign is_cool  = t_ext >= (sp_ext + band_ext);
    assign is_equal = (t_ext == sp_ext);

    always_comb begin
        up_sum    = {1'b0, r_setpoint} + {1'b0, i_cfg.setpoint_step};
        down_diff = {1'b0, r_setpoint} - {1'b0, i_cfg.setpoint_step};
        up_sp     = r_setpoint;
        down_sp   = r_setpoint;
        if (r_setpoint < i_cfg.setpoint_max) begin
            up_sp = (up_sum > {1'b0, i_cfg.setpoint_max}) ? i_cfg.setpoint_max
                                                           : up_sum[7:0];
        end
        if (r_setpoint > i_cfg.setpoint_min) begin
            down_sp = (down_diff[8] || (down_diff[7:0] < i_cfg.setpoint_min))
                      ? i_cfg.setpoint_min : down_diff[7:0];
        end
    end

    always_comb begin
        n_power      = r_power;
        n_adjust     = r_adjust;
        n_setpoint   = r_setpoint;
        n_timeout    = r_timeout;
        n_latch      = r_latch;
        n_ind        = r_ind;
        n_phase      = r_phase;
        n_sdig_high  = r_sdig_high;
        n_sdig_mid   = r_sdig_mid;
        n_sdig_low   = r_sdig_low;
        n_scan_valid = 1'b0;
        n_scan_pos   = '0;
        case (i_entry.cmd)
            CMD_SAMPLE: begin
                n_sdig_high = hund;
                n_sdig_mid  = i_entry.dig_mid;
                n_sdig_low  = i_entry.dig_low;
                if (r_power && !r_adjust) begin
                    if (is_heat) begin
                        n_ind   = IND_HEAT;
                        n_latch = 1'b1;
                    end else if (is_cool) begin
                        n_ind   = IND_COOL;
                        n_latch = 1'b1;
                    end else if (!r_latch) begin
                        n_ind = IND_READY;
                    end else if (is_equal) begin
                        n_latch = 1'b0;
                        n_ind   = IND_READY;
                    end
                end
            end
            CMD_POWER: begin
                if (r_power) begin
                    n_power = 1'b0;
                    n_ind   = IND_OFF;
                end else begin
                    n_power = 1'b1;
                end
            end
            CMD_UP, CMD_DOWN: begin
                if (r_adjust) begin
                    n_setpoint = (i_entry.cmd == CMD_UP) ? up_sp : down_sp;
                end else begin
                    n_adjust = 1'b1;
                end
                n_timeout = i_cfg.timeout_reload;
                if (i_cfg.timeout_reload == '0) begin
                    n_adjust = 1'b0;
                end
            end
            CMD_TICK: begin
                if (r_timeout != '0) begin
                    n_timeout = r_timeout - 8'd1;
                end
                if (r_timeout <= 8'd1) begin
                    n_adjust = 1'b0;
                end
            end
            CMD_SCAN: begin
                if (r_power) begin
                    if (r_phase != SCAN_PHASE_IDLE) begin
                        n_scan_valid = 1'b1;
                        n_scan_pos   = r_phase - SCAN_PHASE_FIRST;
                    end
                    n_phase = (r_phase == SCAN_PHASE_LAST) ? SCAN_PHASE_FIRST
                                                           : r_phase + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power     <= 1'b0;
            r_adjust    <= 1'b0;
            r_setpoint  <= RST_SETPOINT;
            r_timeout   <= '0;
            r_latch     <= 1'b0;
            r_ind       <= IND_OFF;
            r_phase     <= SCAN_PHASE_IDLE;
            r_sdig_high <= '0;
            r_sdig_mid  <= '0;
            r_sdig_low  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_power     <= n_power;
                r_adjust    <= n_adjust;
                r_setpoint  <= n_setpoint;
                r_timeout   <= n_timeout;
                r_latch     <= n_latch;
                r_ind       <= n_ind;
                r_phase     <= n_phase;
                r_sdig_high <= n_sdig_high;
                r_sdig_mid  <= n_sdig_mid;
                r_sdig_low  <= n_sdig_low;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_ind        <= n_ind;
            r_out_powered    <= n_power;
            r_out_adjusting  <= n_adjust;
            r_out_setpoint   <= n_setpoint;
            r_out_sdig_high  <= n_sdig_high;
            r_out_sdig_mid   <= n_sdig_mid;
            r_out_sdig_low   <= n_sdig_low;
            r_out_scan_valid <= n_scan_valid;
            r_out_scan_pos   <= n_scan_pos;
        end
    end

    assign sp_tens_raw = f_div10(16'(r_out_setpoint));
    assign sp_ones     = f_rem10(16'(r_out_setpoint), sp_tens_raw);
    assign sp_tens5    = sp_tens_raw[4:0];

    always_comb begin
        if (sp_tens5 >= 5'd20) begin
            sp_tens_dig = sp_tens5 - 5'd20;
        end else if (sp_tens5 >= 5'd10) begin
            sp_tens_dig = sp_tens5 - 5'd10;
        end else begin
            sp_tens_dig = sp_tens5;
        end
    end

    always_comb begin
        if (!r_out_powered) begin
            o_digit_high = CODE_BLANK;
            o_digit_mid  = CODE_BLANK;
            o_digit_low  = CODE_BLANK;
        end else if (r_out_adjusting) begin
            o_digit_high = CODE_F;
            o_digit_mid  = sp_tens_dig[DIGIT_BITS-1:0];
            o_digit_low  = sp_ones;
        end else begin
            o_digit_high = r_out_sdig_high;
            o_digit_mid  = r_out_sdig_mid;
            o_digit_low  = r_out_sdig_low;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_heat_on          = r_out_ind[0];
    assign o_cool_on          = r_out_ind[1];
    assign o_ready_on         = r_out_ind[2];
    assign o_powered          = r_out_powered;
    assign o_adjusting        = r_out_adjusting;
    assign o_current_setpoint = r_out_setpoint;
    assign o_scan_valid       = r_out_scan_valid;
    assign o_scan_position    = r_out_scan_pos;

    `THC_ASSERT_SAME(a_dark_when_off, i_clk, i_rst_n, !r_power, r_ind == IND_OFF, "indicator lit while off")
    `THC_ASSERT_SAME(a_single_ind, i_clk, i_rst_n, 1'b1, $onehot0(r_ind), "several indicators lit")
    `THC_ASSERT_SAME(a_adjust_timed, i_clk, i_rst_n, r_adjust, r_timeout != '0, "adjust mode without timeout")
    `THC_ASSERT_NEXT(a_scan_moves, i_clk, i_rst_n, pop && (i_entry.cmd == CMD_SCAN) && r_power, r_out_valid && (r_phase != SCAN_PHASE_IDLE), "scan phase did not advance")

endmodule
